// ----- design/ucfb_pkg.sv -----
`default_nettype none

package ucfb_pkg;

  // Command buffer geometry
  localparam int BufLen      = 39;
  localparam int AddrW       = 6;
  localparam int CrcSpan     = 37;
  localparam int ForcedLo    = 3;
  localparam int ForcedHi    = 5;
  localparam int StickBase   = 9;
  localparam int StickMax    = 6;
  localparam int StickCrcLo  = 15;
  localparam int StickCrcHi  = 16;
  localparam int StickSteps  = StickMax + 2;

  // Frame geometry: the layout fills the first eight words, the rest is padding
  localparam int MaxWords    = 16;
  localparam int LayoutBytes = 64;
  localparam int LayoutWords = 8;
  localparam int QueueDepth  = 2;

  // Input opcodes
  localparam logic [1:0] OP_WRITE_BYTE  = 2'd0;
  localparam logic [1:0] OP_WRITE_STICK = 2'd1;
  localparam logic [1:0] OP_TICK        = 2'd2;

  // Fixed frame bytes
  localparam logic [7:0] SYNC0       = 8'h6F;
  localparam logic [7:0] SYNC1       = 8'hEB;
  localparam logic [7:0] SYNC2       = 8'h90;
  localparam logic [7:0] MARK_A      = 8'hAA;
  localparam logic [7:0] MARK_B      = 8'h55;
  localparam logic [7:0] FORCED_BYTE = 8'h01;

  // CRC-16/CCITT-FALSE
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef enum logic [1:0] {
    CMD_BYTE,
    CMD_STICK,
    CMD_TICK
  } cmd_e;

  typedef struct packed {
    cmd_e        kind;
    logic [5:0]  index;
    logic [7:0]  value;
    logic [47:0] stick;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STICK,
    ST_WALK,
    ST_EMIT
  } state_e;

  // Advance the CRC by one byte, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- design/ucfb_ram.sv -----
`default_nettype none

module ucfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 39
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- design/ucfb_front.sv -----
`default_nettype none

module ucfb_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [1:0]    opcode_i,
  input  wire logic [5:0]    byte_index_i,
  input  wire logic [7:0]    byte_value_i,
  input  wire logic [47:0]   stick_bytes_i,
  output logic               push_o,
  output ucfb_pkg::cmd_t     push_cmd_o,
  input  wire logic          push_ready_i
);

  logic        hold_valid_q;
  logic [1:0]  opcode_q;
  logic [5:0]  index_q;
  logic [7:0]  value_q;
  logic [47:0] stick_q;
  logic        keep;
  logic        accept;
  logic        drain;

  // Classify the held item; out-of-range writes and the unused opcode are dropped
  always_comb begin
    keep             = 1'b0;
    push_cmd_o.kind  = ucfb_pkg::CMD_TICK;
    push_cmd_o.index = index_q;
    push_cmd_o.value = value_q;
    push_cmd_o.stick = stick_q;
    case (opcode_q)
      ucfb_pkg::OP_WRITE_BYTE: begin
        push_cmd_o.kind = ucfb_pkg::CMD_BYTE;
        keep            = index_q < 6'(ucfb_pkg::BufLen);
      end
      ucfb_pkg::OP_WRITE_STICK: begin
        push_cmd_o.kind = ucfb_pkg::CMD_STICK;
        keep            = 1'b1;
      end
      ucfb_pkg::OP_TICK: begin
        push_cmd_o.kind = ucfb_pkg::CMD_TICK;
        keep            = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign push_o     = hold_valid_q && keep;
  assign drain      = hold_valid_q && (!keep || push_ready_i);
  assign in_stall_o = hold_valid_q && keep && !push_ready_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Hold one item until it moves into the queue or is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else if (accept) begin
      hold_valid_q <= 1'b1;
    end else if (drain) begin
      hold_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      opcode_q <= opcode_i;
      index_q  <= byte_index_i;
      value_q  <= byte_value_i;
      stick_q  <= stick_bytes_i;
    end
  end

endmodule

`default_nettype wire

// ----- design/ucfb_queue.sv -----
`default_nettype none

module ucfb_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire ucfb_pkg::cmd_t push_cmd_i,
  output logic                push_ready_o,
  input  wire logic           pop_i,
  output logic                pop_valid_o,
  output ucfb_pkg::cmd_t      pop_cmd_o
);

  localparam int PtrW = $clog2(ucfb_pkg::QueueDepth);
  localparam int CntW = $clog2(ucfb_pkg::QueueDepth + 1);

  ucfb_pkg::cmd_t  entry_q [ucfb_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push;
  logic            do_pop;

  assign push_ready_o = count_q != CntW'(ucfb_pkg::QueueDepth);
  assign pop_valid_o  = count_q != '0;
  assign pop_cmd_o    = entry_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

// ----- design/ucfb_back.sv -----
`default_nettype none

module ucfb_back #(
  parameter int FRAME_BYTES = 128,
  parameter int STICK_BYTES = 6
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           q_valid_i,
  input  wire ucfb_pkg::cmd_t q_cmd_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output logic [63:0]         frame_word_o,
  output logic                last_word_o,
  output logic                carried_command_o
);

  localparam int RawWords = (FRAME_BYTES + 7) / 8;
  localparam int NWords   = (RawWords > ucfb_pkg::MaxWords) ? ucfb_pkg::MaxWords : RawWords;
  localparam int WordW    = $clog2(NWords);
  localparam int AW       = ucfb_pkg::AddrW;

  ucfb_pkg::state_e state_q, state_d;

  logic [5:0]                 step_q;
  logic [15:0]                crc_q;
  logic [47:0]                stick_q;
  logic                       carried_q;
  logic                       pending_q;
  logic [ucfb_pkg::BufLen-1:0] vld_q;
  logic                       rd_vld_q;
  logic [7:0]                 pay_q [ucfb_pkg::CrcSpan];
  logic [WordW-1:0]           word_q;
  logic                       out_valid_q;
  logic [63:0]                frame_word_q;
  logic                       last_q;
  logic                       carried_out_q;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;
  logic          walk_take;
  logic          walk_done;
  logic [7:0]    walk_byte;
  logic          out_load;
  logic          word_last;
  logic [7:0]    frame_b [ucfb_pkg::LayoutBytes];
  logic [63:0]   word_sel;

  ucfb_ram #(
    .WIDTH (8),
    .DEPTH (ucfb_pkg::BufLen)
  ) u_ucfb_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign walk_done = (state_q == ucfb_pkg::ST_WALK) && (step_q == 6'(ucfb_pkg::CrcSpan));
  assign word_last = word_q == WordW'(NWords - 1);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ucfb_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          case (q_cmd_i.kind)
            ucfb_pkg::CMD_STICK: state_d = ucfb_pkg::ST_STICK;
            ucfb_pkg::CMD_TICK:  state_d = ucfb_pkg::ST_WALK;
            default:             state_d = ucfb_pkg::ST_IDLE;
          endcase
        end
      end
      ucfb_pkg::ST_STICK: begin
        if (step_q == 6'(ucfb_pkg::StickSteps - 1)) state_d = ucfb_pkg::ST_IDLE;
      end
      ucfb_pkg::ST_WALK: begin
        if (walk_done) state_d = ucfb_pkg::ST_EMIT;
      end
      ucfb_pkg::ST_EMIT: begin
        if (out_load && word_last) state_d = ucfb_pkg::ST_IDLE;
      end
      default: state_d = ucfb_pkg::ST_IDLE;
    endcase
  end

  // State outputs: queue pop, buffer port, walk and emit strobes
  always_comb begin
    q_pop_o   = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    walk_take = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      ucfb_pkg::ST_IDLE: begin
        q_pop_o = q_valid_i;
        if (q_valid_i && (q_cmd_i.kind == ucfb_pkg::CMD_BYTE)) begin
          ram_we    = 1'b1;
          ram_waddr = q_cmd_i.index;
          ram_wdata = q_cmd_i.value;
        end
      end
      ucfb_pkg::ST_STICK: begin
        if (step_q < 6'(ucfb_pkg::StickMax)) begin
          ram_we    = int'(step_q) < STICK_BYTES;
          ram_waddr = AW'(ucfb_pkg::StickBase) + step_q;
          ram_wdata = stick_q[7:0];
        end else if (step_q == 6'(ucfb_pkg::StickMax)) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(ucfb_pkg::StickCrcLo);
          ram_wdata = crc_q[7:0];
        end else begin
          ram_we    = 1'b1;
          ram_waddr = AW'(ucfb_pkg::StickCrcHi);
          ram_wdata = crc_q[15:8];
        end
      end
      ucfb_pkg::ST_WALK: begin
        ram_re    = step_q < 6'(ucfb_pkg::CrcSpan);
        ram_raddr = step_q;
        walk_take = step_q != '0;
      end
      ucfb_pkg::ST_EMIT: begin
        out_load = !out_valid_q || !out_stall_i;
      end
      default: ;
    endcase
  end

  // Byte seen by the walk: header bytes forced, never-written bytes read as zero
  always_comb begin
    if ((step_q >= 6'(ucfb_pkg::ForcedLo + 1)) && (step_q <= 6'(ucfb_pkg::ForcedHi + 1))) begin
      walk_byte = ucfb_pkg::FORCED_BYTE;
    end else begin
      walk_byte = rd_vld_q ? ram_rdata : 8'h00;
    end
  end

  // Frame layout of the first eight words
  always_comb begin
    for (int i = 0; i < ucfb_pkg::LayoutBytes; i++) begin
      frame_b[i] = 8'h00;
    end
    frame_b[0]  = ucfb_pkg::SYNC0;
    frame_b[1]  = ucfb_pkg::SYNC1;
    frame_b[2]  = ucfb_pkg::SYNC2;
    for (int i = 0; i < 16; i++) begin
      frame_b[3 + i] = pay_q[i];
    end
    frame_b[27] = pay_q[16];
    frame_b[28] = pay_q[17];
    frame_b[29] = ucfb_pkg::MARK_A;
    frame_b[30] = ucfb_pkg::MARK_B;
    frame_b[31] = ucfb_pkg::MARK_A;
    frame_b[32] = ucfb_pkg::SYNC0;
    for (int i = 0; i < 18; i++) begin
      frame_b[33 + i] = pay_q[18 + i];
    end
    frame_b[59] = pay_q[36];
    frame_b[60] = crc_q[7:0];
    frame_b[61] = crc_q[15:8];
    frame_b[62] = ucfb_pkg::SYNC1;
    frame_b[63] = ucfb_pkg::SYNC2;
    // Drop layout bytes past the frame length
    for (int i = 0; i < ucfb_pkg::LayoutBytes; i++) begin
      if (i >= FRAME_BYTES) frame_b[i] = 8'h00;
    end
  end

  // Pick the current word; words past the layout are padding
  always_comb begin
    word_sel = '0;
    if ({1'b0, word_q} < (WordW + 1)'(ucfb_pkg::LayoutWords)) begin
      for (int i = 0; i < 8; i++) begin
        word_sel[8*i +: 8] = frame_b[{word_q[2:0], 3'(i)}];
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ucfb_pkg::ST_IDLE;
      step_q      <= '0;
      pending_q   <= 1'b0;
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
      word_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= vld_q[ram_raddr];

      case (state_q)
        ucfb_pkg::ST_IDLE:                    step_q <= '0;
        ucfb_pkg::ST_STICK, ucfb_pkg::ST_WALK: step_q <= step_q + 6'd1;
        default: ;
      endcase

      // Mark the buffer pending on any accepted write
      if (q_pop_o && (q_cmd_i.kind != ucfb_pkg::CMD_TICK)) begin
        pending_q <= 1'b1;
      end else if (walk_done) begin
        pending_q <= 1'b0;
      end

      // Mark written bytes; the tick empties the buffer once it is read
      if (walk_done) begin
        vld_q <= '0;
      end else if (ram_we) begin
        vld_q[ram_waddr] <= 1'b1;
      end

      if (state_q == ucfb_pkg::ST_IDLE) begin
        word_q <= '0;
      end else if (out_load) begin
        word_q <= word_q + WordW'(1);
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ucfb_pkg::ST_IDLE) begin
      crc_q   <= ucfb_pkg::CRC_INIT;
      stick_q <= q_cmd_i.stick;
    end else if ((state_q == ucfb_pkg::ST_STICK) && (step_q < 6'(ucfb_pkg::StickMax))) begin
      crc_q   <= ucfb_pkg::crc_byte(crc_q, stick_q[7:0]);
      stick_q <= {8'h00, stick_q[47:8]};
    end else if (walk_take) begin
      crc_q <= ucfb_pkg::crc_byte(crc_q, walk_byte);
    end

    if (q_pop_o && (q_cmd_i.kind == ucfb_pkg::CMD_TICK)) begin
      carried_q <= pending_q;
    end

    // Shift the payload line as the walk reads it
    if (walk_take) begin
      for (int i = 0; i < ucfb_pkg::CrcSpan - 1; i++) begin
        pay_q[i] <= pay_q[i + 1];
      end
      pay_q[ucfb_pkg::CrcSpan - 1] <= walk_byte;
    end

    if (out_load) begin
      frame_word_q  <= word_sel;
      last_q        <= word_last;
      carried_out_q <= carried_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign frame_word_o      = frame_word_q;
  assign last_word_o       = last_q;
  assign carried_command_o = carried_out_q;

endmodule

`default_nettype wire

// ----- design/uplink_control_frame_builder.sv -----
// Uplink control frame builder.
// Input channel (in_valid_i / in_stall_o) takes one command per transfer:
// opcode 0 writes one byte of the 39-byte command buffer, opcode 1 writes the
// stick bytes at positions 9 on with their CRC at 15-16, opcode 2 is a tick.
// A tick emits one frame on the output channel (out_valid_o / out_stall_i)
// as ceil(FRAME_BYTES/8) words (capped at 16), last_word_o marking the final one.
// A front register classifies commands and a two-entry queue feeds the back
// end, which owns the buffer RAM and runs one command at a time.
// Back end work: a byte write is done as it is popped, a stick write steps
// through the stick bytes and both CRC bytes, and a tick pops, walks the CRC
// over the buffer (one buffer byte per cycle through the RAM read port), then
// emits the frame one word at a time.
// A stall on the output holds the current word; the back end waits, the
// queue fills, and then in_stall_o rises.
// Reset empties the buffer and clears the pending flag at once; the block
// accepts commands in the first cycle after reset.
`default_nettype none

module uplink_control_frame_builder #(
  parameter int FRAME_BYTES = 128,
  parameter int STICK_BYTES = 6
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [5:0]  byte_index_i,
  input  wire logic [7:0]  byte_value_i,
  input  wire logic [47:0] stick_bytes_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      frame_word_o,
  output logic             last_word_o,
  output logic             carried_command_o
);

  logic           push;
  ucfb_pkg::cmd_t push_cmd;
  logic           push_ready;
  logic           q_valid;
  ucfb_pkg::cmd_t q_cmd;
  logic           q_pop;

  ucfb_front u_ucfb_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .byte_index_i  (byte_index_i),
    .byte_value_i  (byte_value_i),
    .stick_bytes_i (stick_bytes_i),
    .push_o        (push),
    .push_cmd_o    (push_cmd),
    .push_ready_i  (push_ready)
  );

  ucfb_queue u_ucfb_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_cmd_i   (push_cmd),
    .push_ready_o (push_ready),
    .pop_i        (q_pop),
    .pop_valid_o  (q_valid),
    .pop_cmd_o    (q_cmd)
  );

  ucfb_back #(
    .FRAME_BYTES (FRAME_BYTES),
    .STICK_BYTES (STICK_BYTES)
  ) u_ucfb_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_valid_i         (q_valid),
    .q_cmd_i           (q_cmd),
    .q_pop_o           (q_pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .frame_word_o      (frame_word_o),
    .last_word_o       (last_word_o),
    .carried_command_o (carried_command_o)
  );

endmodule

`default_nettype wire

// ----- design/ucfb_checker.sv -----
`default_nettype none

module ucfb_checker #(
  parameter int FRAME_BYTES = 128
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [63:0] frame_word_o,
  input wire logic        last_word_o,
  input wire logic        carried_command_o
);

  localparam int RawWords = (FRAME_BYTES + 7) / 8;
  localparam int NWords   = (RawWords > ucfb_pkg::MaxWords) ? ucfb_pkg::MaxWords : RawWords;
  localparam int CntW     = $clog2(ucfb_pkg::MaxWords);

  logic [CntW-1:0] cnt_q;
  logic            first_carried_q;
  logic            xfer;

  assign xfer = out_valid_o && !out_stall_i;

  // Track the word position within the current frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q           <= '0;
      first_carried_q <= 1'b0;
    end else if (xfer) begin
      cnt_q <= last_word_o ? '0 : cnt_q + CntW'(1);
      if (cnt_q == '0) first_carried_q <= carried_command_o;
    end
  end

  // Hold a stalled word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(frame_word_o)
      && $stable(last_word_o) && $stable(carried_command_o))
    else $error("stalled output word changed");

  // Last-word flag only on the final word of the frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_word_o == (cnt_q == CntW'(NWords - 1))))
    else $error("last_word_o out of place");

  // Every frame opens with the sync pattern
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (cnt_q == '0) |->
      frame_word_o[23:0] == {ucfb_pkg::SYNC2, ucfb_pkg::SYNC1, ucfb_pkg::SYNC0})
    else $error("frame does not start with sync bytes");

  // Carried flag is constant over a frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (cnt_q != '0) |-> carried_command_o == first_carried_q)
    else $error("carried_command_o changed within a frame");

endmodule

bind uplink_control_frame_builder ucfb_checker #(
  .FRAME_BYTES (FRAME_BYTES)
) u_ucfb_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .frame_word_o      (frame_word_o),
  .last_word_o       (last_word_o),
  .carried_command_o (carried_command_o)
);

`default_nettype wire

// ----- verif/testbench.sv -----
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_BYTES  = 128;
  localparam int STICK_BYTES  = 6;
  localparam int RANDOM_ITEMS = 90;
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PRESSURE_LEN = 400;
  localparam int REPORT_MAX   = 10;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [5:0]  index;
    logic [7:0]  value;
    logic [47:0] stick;
  } uplink_cmd_t;

  typedef struct packed {
    logic [63:0] word;
    logic        last;
    logic        carried;
  } frame_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  opcode_i = OP_UNUSED;
  logic [5:0]  byte_index_i = '0;
  logic [7:0]  byte_value_i = '0;
  logic [47:0] stick_bytes_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] frame_word_o;
  logic        last_word_o;
  logic        carried_command_o;

  uplink_control_frame_builder #(
    .FRAME_BYTES(FRAME_BYTES),
    .STICK_BYTES(STICK_BYTES)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .opcode_i         (opcode_i),
    .byte_index_i     (byte_index_i),
    .byte_value_i     (byte_value_i),
    .stick_bytes_i    (stick_bytes_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .frame_word_o     (frame_word_o),
    .last_word_o      (last_word_o),
    .carried_command_o(carried_command_o)
  );

  // Free-running clock
  always #5 clk_i = ~clk_i;

  uplink_cmd_t uplink_cmds_q[$];
  frame_beat_t frame_beats_q[$];

  logic [7:0] shadow_buf [0:ucfb_pkg::BufLen-1];
  logic       shadow_pending;
  int         mismatches = 0;
  int         cmds_accepted = 0;
  int         directed_count;

  // One byte of CRC-16/CCITT-FALSE, MSB first
  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] acc;
    logic        fb;
    acc = crc;
    for (int b = 7; b >= 0; b--) begin
      fb = acc[15] ^ data[b];
      acc = {acc[14:0], 1'b0};
      if (fb) acc = acc ^ ucfb_pkg::CRC_POLY;
    end
    return acc;
  endfunction

  // Apply one accepted command to the shadow buffer, queue any frame it emits
  task automatic predict_command(input uplink_cmd_t cmd);
    logic [7:0]  payload [0:ucfb_pkg::BufLen-1];
    logic [7:0]  frame_bytes [0:ucfb_pkg::MaxWords*8-1];
    logic [7:0]  stick_b [0:ucfb_pkg::StickMax-1];
    logic [15:0] crc;
    logic        carried;
    frame_beat_t beat;
    int          nwords;
    case (cmd.opcode)
      ucfb_pkg::OP_WRITE_BYTE: begin
        if (cmd.index < ucfb_pkg::BufLen) begin
          shadow_buf[cmd.index] = cmd.value;
          shadow_pending = 1'b1;
        end
      end
      ucfb_pkg::OP_WRITE_STICK: begin
        crc = ucfb_pkg::CRC_INIT;
        for (int i = 0; i < ucfb_pkg::StickMax; i++) begin
          stick_b[i] = cmd.stick[8*i +: 8];
          crc = crc16_update(crc, stick_b[i]);
        end
        for (int i = 0; i < STICK_BYTES && i < ucfb_pkg::StickMax; i++)
          shadow_buf[ucfb_pkg::StickBase + i] = stick_b[i];
        shadow_buf[ucfb_pkg::StickCrcLo] = crc[7:0];
        shadow_buf[ucfb_pkg::StickCrcHi] = crc[15:8];
        shadow_pending = 1'b1;
      end
      ucfb_pkg::OP_TICK: begin
        carried = shadow_pending;
        for (int i = 0; i < ucfb_pkg::BufLen; i++) begin
          payload[i] = carried ? shadow_buf[i] : 8'h00;
          shadow_buf[i] = 8'h00;
        end
        shadow_pending = 1'b0;
        for (int i = ucfb_pkg::ForcedLo; i <= ucfb_pkg::ForcedHi; i++)
          payload[i] = ucfb_pkg::FORCED_BYTE;
        crc = ucfb_pkg::CRC_INIT;
        for (int i = 0; i < ucfb_pkg::CrcSpan; i++) crc = crc16_update(crc, payload[i]);
        payload[ucfb_pkg::CrcSpan]     = crc[7:0];
        payload[ucfb_pkg::CrcSpan + 1] = crc[15:8];

        // Lay out sync, payload and markers; everything else stays zero
        for (int i = 0; i < ucfb_pkg::MaxWords*8; i++) frame_bytes[i] = 8'h00;
        frame_bytes[0] = ucfb_pkg::SYNC0;
        frame_bytes[1] = ucfb_pkg::SYNC1;
        frame_bytes[2] = ucfb_pkg::SYNC2;
        for (int i = 0; i < 16; i++) frame_bytes[3 + i] = payload[i];
        frame_bytes[27] = payload[16];
        frame_bytes[28] = payload[17];
        frame_bytes[29] = ucfb_pkg::MARK_A;
        frame_bytes[30] = ucfb_pkg::MARK_B;
        frame_bytes[31] = ucfb_pkg::MARK_A;
        frame_bytes[32] = ucfb_pkg::SYNC0;
        for (int i = 0; i < 18; i++) frame_bytes[33 + i] = payload[18 + i];
        frame_bytes[59] = payload[36];
        frame_bytes[60] = payload[37];
        frame_bytes[61] = payload[38];
        frame_bytes[62] = ucfb_pkg::SYNC1;
        frame_bytes[63] = ucfb_pkg::SYNC2;

        nwords = (FRAME_BYTES + 7) / 8;
        if (nwords > ucfb_pkg::MaxWords) nwords = ucfb_pkg::MaxWords;
        for (int k = 0; k < nwords; k++) begin
          for (int b = 0; b < 8; b++)
            beat.word[8*b +: 8] = (k*8 + b < FRAME_BYTES) ? frame_bytes[k*8 + b] : 8'h00;
          beat.last    = (k == nwords - 1);
          beat.carried = carried;
          frame_beats_q.push_back(beat);
        end
      end
      default: ;
    endcase
  endtask

  function automatic uplink_cmd_t random_cmd(input logic [1:0] op);
    uplink_cmd_t c;
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    c.opcode = op;
    c.index  = 6'($urandom_range(0, ucfb_pkg::BufLen - 1));
    c.value  = 8'($urandom);
    c.stick  = wide[47:0];
    return c;
  endfunction

  task automatic push_byte(input int idx, input logic [7:0] val);
    uplink_cmd_t c;
    c = random_cmd(ucfb_pkg::OP_WRITE_BYTE);
    c.index = 6'(idx);
    c.value = val;
    uplink_cmds_q.push_back(c);
  endtask

  task automatic push_stick(input logic [47:0] sticks);
    uplink_cmd_t c;
    c = random_cmd(ucfb_pkg::OP_WRITE_STICK);
    c.stick = sticks;
    uplink_cmds_q.push_back(c);
  endtask

  task automatic push_op(input logic [1:0] op);
    uplink_cmds_q.push_back(random_cmd(op));
  endtask

  // Build the command list: directed part, then random frames and noise
  task automatic build_stimulus();
    int          effective;
    int          writes;
    uplink_cmd_t c;
    // Tick with nothing pending, then edge bytes, forced and CRC positions
    push_op(ucfb_pkg::OP_TICK);
    push_byte(0, 8'hFF);
    push_byte(ucfb_pkg::BufLen - 1, 8'hFF);
    push_byte(ucfb_pkg::ForcedLo, 8'h00);
    push_byte(ucfb_pkg::CrcSpan, 8'hAA);
    push_byte(ucfb_pkg::BufLen, 8'h55);
    push_op(OP_UNUSED);
    push_op(ucfb_pkg::OP_TICK);
    // Out-of-range write alone must not mark the buffer pending
    push_byte(63, 8'h12);
    push_op(OP_UNUSED);
    push_op(ucfb_pkg::OP_TICK);
    push_stick({48{1'b1}});
    push_op(ucfb_pkg::OP_TICK);
    push_stick(48'h0);
    push_byte(ucfb_pkg::StickCrcLo, 8'h00);
    push_op(ucfb_pkg::OP_TICK);
    push_byte(ucfb_pkg::StickBase, 8'h80);
    push_byte(ucfb_pkg::StickCrcHi, 8'h01);
    push_op(ucfb_pkg::OP_TICK);
    push_op(ucfb_pkg::OP_TICK);
    directed_count = uplink_cmds_q.size();

    effective = 0;
    while (effective < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 7) begin
        // Well-formed: a few writes, then a tick
        writes = $urandom_range(1, 6);
        for (int i = 0; i < writes; i++) begin
          if ($urandom_range(0, 3) == 0) push_op(ucfb_pkg::OP_WRITE_STICK);
          else push_op(ucfb_pkg::OP_WRITE_BYTE);
        end
        push_op(ucfb_pkg::OP_TICK);
        effective += writes + 1;
      end else begin
        // Noise: any opcode, any index
        c = random_cmd(2'($urandom_range(0, 3)));
        c.index = 6'($urandom_range(0, 63));
        uplink_cmds_q.push_back(c);
        effective++;
      end
    end
  endtask

  // Driver: present queued commands with random gaps, hold while stalled
  int gap_left = 0;
  int send_burst = 0;
  uplink_cmd_t head_cmd;

  always @(posedge clk_i) begin
    if (rst_ni && !(in_valid_i && in_stall_o)) begin
      if (in_valid_i) begin
        head_cmd = uplink_cmds_q.pop_front();
        predict_command(head_cmd);
        cmds_accepted <= cmds_accepted + 1;
        if (send_burst > 0) begin
          send_burst--;
          gap_left = 0;
        end else begin
          case ($urandom_range(0, 19))
            0:       gap_left = $urandom_range(10, 60);
            1:       send_burst = $urandom_range(10, 30);
            2, 3, 4, 5, 6, 7: gap_left = $urandom_range(1, 3);
            default: gap_left = 0;
          endcase
        end
      end
      if (gap_left > 0 || uplink_cmds_q.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i    <= 1'b1;
        opcode_i      <= uplink_cmds_q[0].opcode;
        byte_index_i  <= uplink_cmds_q[0].index;
        byte_value_i  <= uplink_cmds_q[0].value;
        stick_bytes_i <= uplink_cmds_q[0].stick;
      end
    end
  end

  // Receiver stall: short and long holds, quiet stretches, one long hold-off
  int  hold_left = 0;
  int  stall_quiet = 0;
  bit  pressure_done = 1'b0;
  int  stall_roll;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      stall_roll = $urandom_range(0, 99);
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (!pressure_done && out_valid_o && cmds_accepted > directed_count) begin
        pressure_done = 1'b1;
        hold_left = PRESSURE_LEN;
        out_stall_i <= 1'b1;
      end else if (stall_quiet > 0) begin
        stall_quiet--;
        out_stall_i <= 1'b0;
      end else if (stall_roll < 60) begin
        out_stall_i <= 1'b0;
      end else if (stall_roll < 92) begin
        hold_left = $urandom_range(0, 3);
        out_stall_i <= 1'b1;
      end else if (stall_roll < 96) begin
        hold_left = $urandom_range(10, 60);
        out_stall_i <= 1'b1;
      end else begin
        stall_quiet = $urandom_range(20, 100);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Monitor: compare each word transfer with the oldest expected beat
  frame_beat_t want;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (frame_beats_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected word %h last %b carried %b",
                   frame_word_o, last_word_o, carried_command_o);
      end else begin
        want = frame_beats_q.pop_front();
        if (frame_word_o !== want.word || last_word_o !== want.last ||
            carried_command_o !== want.carried) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("word mismatch: expected %h/%b/%b actual %h/%b/%b",
                     want.word, want.last, want.carried,
                     frame_word_o, last_word_o, carried_command_o);
        end
      end
    end
  end

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("testbench: FAIL");
    $finish;
  end

  // Reset, stimulus, drain and verdict
  initial begin
    for (int i = 0; i < ucfb_pkg::BufLen; i++) shadow_buf[i] = 8'h00;
    shadow_pending = 1'b0;
    build_stimulus();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    while (uplink_cmds_q.size() > 0 || in_valid_i) @(negedge clk_i);
    while (frame_beats_q.size() > 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (frame_beats_q.size() > 0) begin
      mismatches++;
      $display("%0d expected words never arrived", frame_beats_q.size());
    end
    if (mismatches == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
design/ucfb_pkg.sv
design/ucfb_ram.sv
design/ucfb_front.sv
design/ucfb_queue.sv
design/ucfb_back.sv
design/uplink_control_frame_builder.sv
design/ucfb_checker.sv
verif/testbench.sv
